// ===== sv/wmc_pkg.sv =====
// Package for the weighted measurement combiner.
// Holds sequencer codes, the sign-magnitude type and saturation helpers.
// No dependencies.
package wmc_pkg;

  localparam int unsigned CoordWidthDef = 32;
  localparam int unsigned CovWidth      = 32;
  localparam int unsigned WeightWidth   = 17;
  localparam logic [WeightWidth-1:0] MinWeightRst = 17'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_OUT
  } st_e;

  typedef enum logic [1:0] {
    K_MUL,
    K_DIV,
    K_ALU
  } kind_e;

  typedef enum logic [4:0] {
    H_DETA, H_DETB, H_NXX, H_QXX, H_NXY, H_QXY, H_NYY, H_QYY, H_ACC,
    H_VX0, H_VX1, H_VXA, H_VY0, H_VY1, H_VYA,
    C_DETA, C_DETB, C_QXX, C_QXY, C_QYY, C_X0, C_X1, C_XA, C_Y0, C_Y1, C_YA,
    S_QXX, S_QXY, S_QYY
  } step_e;

  typedef struct packed {
    logic         neg;
    logic [127:0] mag;
  } sm_t;

  function automatic kind_e step_kind(step_e s);
    kind_e k;
    case (s)
      H_ACC, H_VXA, H_VYA, C_XA, C_YA: k = K_ALU;
      H_QXX, H_QXY, H_QYY, C_QXX, C_QXY, C_QYY, S_QXX, S_QXY, S_QYY: k = K_DIV;
      default: k = K_MUL;
    endcase
    return k;
  endfunction

  function automatic sm_t sm_mk(logic n, logic [127:0] m);
    sm_t r;
    r.neg = n && (m != 128'd0);
    r.mag = m;
    return r;
  endfunction

  function automatic logic [63:0] mag64(logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  function automatic sm_t sm_from64(logic [63:0] v);
    return sm_mk(v[63], {64'd0, mag64(v)});
  endfunction

  function automatic sm_t sm_add(sm_t a, sm_t b);
    sm_t r;
    if (a.neg == b.neg) r = sm_mk(a.neg, a.mag + b.mag);
    else if (a.mag >= b.mag) r = sm_mk(a.neg, a.mag - b.mag);
    else r = sm_mk(b.neg, b.mag - a.mag);
    return r;
  endfunction

  function automatic sm_t sm_shr(sm_t a, logic [6:0] n);
    return sm_mk(a.neg, a.mag >> n);
  endfunction

  function automatic logic [63:0] sat64(sm_t a);
    logic [63:0] r;
    if (!a.neg) begin
      r = (a.mag > 128'h7fff_ffff_ffff_ffff) ? 64'h7fff_ffff_ffff_ffff : a.mag[63:0];
    end else begin
      r = (a.mag > 128'h8000_0000_0000_0000) ? 64'h8000_0000_0000_0000
                                              : (~a.mag[63:0] + 64'd1);
    end
    return r;
  endfunction

  function automatic logic [31:0] sat32(sm_t a);
    logic [31:0] r;
    if (!a.neg) begin
      r = (a.mag > 128'h7fff_ffff) ? 32'h7fff_ffff : a.mag[31:0];
    end else begin
      r = (a.mag > 128'h8000_0000) ? 32'h8000_0000 : (~a.mag[31:0] + 32'd1);
    end
    return r;
  endfunction

  function automatic logic [31:0] u32sat(sm_t a);
    logic [31:0] r;
    if (a.neg) r = 32'd0;
    else if (a.mag > 128'hffff_ffff) r = 32'hffff_ffff;
    else r = a.mag[31:0];
    return r;
  endfunction

  function automatic logic [63:0] acc_add(logic [63:0] acc, sm_t x);
    return sat64(sm_add(sm_from64(acc), x));
  endfunction

endpackage

// ===== sv/wmc_mul.sv =====
// Shared 64x64 unsigned multiplier, one 32x32 partial product per cycle.
// Depends on nothing but the clock and reset.
module wmc_mul (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [63:0]  a_i,
  input  logic [63:0]  b_i,
  output logic         done_o,
  output logic [127:0] prod_o
);

  logic [63:0]  a_q, b_q;
  logic [2:0]   cnt_q;
  logic         busy_q, done_q;
  logic [63:0]  pp_q;
  logic [1:0]   sh_q;
  logic [127:0] acc_q;
  logic [31:0]  ah, bh;

  assign ah = cnt_q[1] ? a_q[63:32] : a_q[31:0];
  assign bh = cnt_q[0] ? b_q[63:32] : b_q[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 3'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd4) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= 128'd0;
    end else if (busy_q) begin
      if (cnt_q != 3'd4) begin
        pp_q <= ah * bh;
        sh_q <= 2'(cnt_q[1]) + 2'(cnt_q[0]);
      end
      if (cnt_q != 3'd0) acc_q <= acc_q + ({64'd0, pp_q} << {sh_q, 5'd0});
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== sv/wmc_div.sv =====
// Shared 128/128 restoring divider, one quotient bit per cycle.
// Depends on nothing but the clock and reset; divisor must be nonzero.
module wmc_div (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [127:0] num_i,
  input  logic [127:0] den_i,
  output logic         done_o,
  output logic [127:0] quo_o
);

  logic [127:0] n_q, d_q, rem_q, q_q;
  logic [6:0]   cnt_q;
  logic         busy_q, done_q;
  logic [128:0] r;
  logic         ge;

  assign r  = {rem_q, n_q[127]};
  assign ge = r >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'd127) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= num_i;
      d_q   <= den_i;
      rem_q <= '0;
      q_q   <= '0;
    end else if (busy_q) begin
      n_q   <= {n_q[126:0], 1'b0};
      rem_q <= ge ? 128'(r - {1'b0, d_q}) : r[127:0];
      q_q   <= {q_q[126:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = q_q;

endmodule

// ===== sv/weighted_measurement_combiner_top.sv =====
// Weighted measurement combiner: sequencer and datapath around one shared
// 64x64 multiplier and one divider; ready is low while a hit is processed.
// The result sits in an output register, so the next item can be taken while it waits.
// Reset clears accumulators and flags and sets min_weight to 1.
module weighted_measurement_combiner_top
  import wmc_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = CoordWidthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // meas_x, meas_y, cov_xx, cov_xy, cov_yy, hit_weight, zero fill
  input  logic [((2*COORD_WIDTH+113+7)/8)*8-1:0] s_axis_tdata,
  input  logic s_axis_tlast,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // comb_x, comb_y, comb_cov_xx, comb_cov_xy, comb_cov_yy, zero fill
  output logic [((2*COORD_WIDTH+96+7)/8)*8-1:0] m_axis_tdata,
  // singular
  output logic m_axis_tuser,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic [WeightWidth-1:0] cfg_data_i
);

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned OUT_W = ((2*COORD_WIDTH+96+7)/8)*8;
  localparam int unsigned C0    = 2*CW;

  function automatic logic [CW-1:0] satcw(sm_t a);
    logic [CW-1:0] r;
    if (!a.neg) begin
      r = (a.mag > ((128'd1 << (CW-1)) - 128'd1)) ? {1'b0, {(CW-1){1'b1}}} : a.mag[CW-1:0];
    end else begin
      r = (a.mag > (128'd1 << (CW-1))) ? {1'b1, {(CW-1){1'b0}}}
                                       : (~a.mag[CW-1:0] + {{(CW-1){1'b0}}, 1'b1});
    end
    return r;
  endfunction

  st_e   st_q, st_d;
  step_e step_q, step_d;

  logic [WeightWidth-1:0] minw_q;
  logic [CW-1:0] mx_q, my_q, mx_d, my_d;
  logic [31:0]   xx_q, xy_q, yy_q, xx_d, xy_d, yy_d;
  logic [WeightWidth-1:0] w_q, w_d, hw, wsel;
  logic          last_q, last_d;
  logic          pend_q, pend_d, sseen_q, sseen_d;
  logic [63:0]   ixx_q, ixy_q, iyy_q, vx_q, vy_q;
  logic [63:0]   ixx_d, ixy_d, iyy_d, vx_d, vy_d;
  logic [63:0]   hxx_q, hxy_q, hyy_q, hxx_d, hxy_d, hyy_d;
  sm_t           p_q, p_d, det_q, det_d, t_q, t_d;
  logic [127:0]  nb_q, nb_d;
  logic [CW-1:0] rx_q, ry_q, rx_d, ry_d;
  logic [31:0]   rcxx_q, rcxy_q, rcyy_q, rcxx_d, rcxy_d, rcyy_d;
  logic          rs_q, rs_d;
  logic          ov_q, ov_d;
  logic [CW-1:0] ox_q, oy_q;
  logic [31:0]   ocxx_q, ocxy_q, ocyy_q;
  logic          os_q;
  logic          load_out;

  logic          mul_start, div_start, mul_done, div_done;
  logic [63:0]   ma, mb;
  logic [127:0]  prod, quo, dnum, dden;
  logic [63:0]   mx64, my64, axy;
  logic          accept, wb;
  kind_e         kind;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (st_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign kind = step_kind(step_q);

  assign mx64 = {{(64-CW){mx_q[CW-1]}}, mx_q};
  assign my64 = {{(64-CW){my_q[CW-1]}}, my_q};
  assign axy  = {32'd0, xy_q[31] ? (~xy_q + 32'd1) : xy_q};

  assign hw   = s_axis_tdata[C0+96 +: WeightWidth];
  assign wsel = (hw < minw_q) ? minw_q : hw;

  wmc_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(ma), .b_i(mb),
    .done_o(mul_done), .prod_o(prod)
  );

  wmc_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(dnum), .den_i(dden),
    .done_o(div_done), .quo_o(quo)
  );

  always_comb begin
    ma = 64'd0;
    mb = 64'd0;
    case (step_q)
      H_DETA:  begin ma = {32'd0, xx_q}; mb = {32'd0, yy_q}; end
      H_DETB:  begin ma = axy; mb = axy; end
      H_NXX:   begin ma = 64'(w_q); mb = {32'd0, yy_q}; end
      H_NXY:   begin ma = 64'(w_q); mb = axy; end
      H_NYY:   begin ma = 64'(w_q); mb = {32'd0, xx_q}; end
      H_VX0:   begin ma = mag64(hxx_q); mb = mag64(mx64); end
      H_VX1:   begin ma = mag64(hxy_q); mb = mag64(my64); end
      H_VY0:   begin ma = mag64(hxy_q); mb = mag64(mx64); end
      H_VY1:   begin ma = mag64(hyy_q); mb = mag64(my64); end
      C_DETA:  begin ma = mag64(ixx_q); mb = mag64(iyy_q); end
      C_DETB:  begin ma = mag64(ixy_q); mb = mag64(ixy_q); end
      C_X0:    begin ma = {32'd0, rcxx_q}; mb = mag64(vx_q); end
      C_X1:    begin ma = mag64({{32{rcxy_q[31]}}, rcxy_q}); mb = mag64(vy_q); end
      C_Y0:    begin ma = mag64({{32{rcxy_q[31]}}, rcxy_q}); mb = mag64(vx_q); end
      C_Y1:    begin ma = {32'd0, rcyy_q}; mb = mag64(vy_q); end
      default: begin ma = 64'd0; mb = 64'd0; end
    endcase
  end

  always_comb begin
    dnum = nb_q << 40;
    dden = det_q.mag;
    case (step_q)
      C_QXX:   dnum = {mag64(iyy_q), 64'd0} >> 8;
      C_QXY:   dnum = {mag64(ixy_q), 64'd0} >> 8;
      C_QYY:   dnum = {mag64(ixx_q), 64'd0} >> 8;
      S_QXX:   begin dnum = {80'd0, xx_q, 16'd0}; dden = 128'(w_q); end
      S_QXY:   begin dnum = {80'd0, axy[31:0], 16'd0}; dden = 128'(w_q); end
      S_QYY:   begin dnum = {80'd0, yy_q, 16'd0}; dden = 128'(w_q); end
      default: dnum = nb_q << 40;
    endcase
  end

  always_comb begin
    st_d = st_q;   step_d = step_q;
    mx_d = mx_q;   my_d = my_q;   xx_d = xx_q;  xy_d = xy_q;  yy_d = yy_q;
    w_d = w_q;     last_d = last_q;
    pend_d = pend_q;  sseen_d = sseen_q;
    ixx_d = ixx_q; ixy_d = ixy_q; iyy_d = iyy_q; vx_d = vx_q; vy_d = vy_q;
    hxx_d = hxx_q; hxy_d = hxy_q; hyy_d = hyy_q;
    p_d = p_q;     det_d = det_q;  t_d = t_q;   nb_d = nb_q;
    rx_d = rx_q;   ry_d = ry_q;   rcxx_d = rcxx_q; rcxy_d = rcxy_q; rcyy_d = rcyy_q;
    rs_d = rs_q;   ov_d = ov_q;
    mul_start = 1'b0;  div_start = 1'b0;  load_out = 1'b0;  wb = 1'b0;

    if (ov_q && m_axis_tready) ov_d = 1'b0;

    case (st_q)
      ST_IDLE: begin
        if (accept) begin
          mx_d   = s_axis_tdata[0 +: CW];
          my_d   = s_axis_tdata[CW +: CW];
          xx_d   = s_axis_tdata[C0 +: 32];
          xy_d   = s_axis_tdata[C0+32 +: 32];
          yy_d   = s_axis_tdata[C0+64 +: 32];
          w_d    = (wsel == '0) ? WeightWidth'(1) : wsel;
          last_d = s_axis_tlast;
          step_d = (s_axis_tlast && !pend_q) ? S_QXX : H_DETA;
          st_d   = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        case (kind)
          K_MUL:   begin mul_start = 1'b1; st_d = ST_WAIT; end
          K_DIV:   begin div_start = 1'b1; st_d = ST_WAIT; end
          default: wb = 1'b1;
        endcase
      end
      ST_WAIT: begin
        if (mul_done || div_done) wb = 1'b1;
      end
      ST_OUT: begin
        if (!ov_q || m_axis_tready) begin
          load_out = 1'b1;
          ov_d  = 1'b1;
          ixx_d = '0; ixy_d = '0; iyy_d = '0; vx_d = '0; vy_d = '0;
          sseen_d = 1'b0;
          pend_d  = 1'b0;
          st_d    = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase

    if (wb) begin
      st_d   = ST_ISSUE;
      step_d = step_e'(step_q + 5'd1);
      case (step_q)
        H_DETA: p_d = sm_mk(1'b0, prod);
        H_DETB: begin
          det_d = sm_add(p_q, sm_mk(1'b1, prod));
          if (det_d.mag == '0) begin
            sseen_d = 1'b1;
            if (last_q) step_d = C_DETA;
            else begin pend_d = 1'b1; st_d = ST_IDLE; end
          end
        end
        H_NXX, H_NXY, H_NYY: nb_d = prod;
        H_QXX: hxx_d = sat64(sm_mk(det_q.neg, quo));
        H_QXY: hxy_d = sat64(sm_mk(!xy_q[31] ^ det_q.neg, quo));
        H_QYY: hyy_d = sat64(sm_mk(det_q.neg, quo));
        H_ACC: begin
          ixx_d = acc_add(ixx_q, sm_from64(hxx_q));
          ixy_d = acc_add(ixy_q, sm_from64(hxy_q));
          iyy_d = acc_add(iyy_q, sm_from64(hyy_q));
        end
        H_VX0: t_d = sm_mk(hxx_q[63] ^ mx64[63], prod);
        H_VX1: t_d = sm_add(t_q, sm_mk(hxy_q[63] ^ my64[63], prod));
        H_VXA: vx_d = acc_add(vx_q, sm_shr(t_q, 7'd24));
        H_VY0: t_d = sm_mk(hxy_q[63] ^ mx64[63], prod);
        H_VY1: t_d = sm_add(t_q, sm_mk(hyy_q[63] ^ my64[63], prod));
        H_VYA: begin
          vy_d = acc_add(vy_q, sm_shr(t_q, 7'd24));
          if (!last_q) begin pend_d = 1'b1; st_d = ST_IDLE; end
        end
        C_DETA: p_d = sm_mk(ixx_q[63] ^ iyy_q[63], prod);
        C_DETB: begin
          det_d = sm_add(p_q, sm_mk(1'b1, prod));
          if (det_d.mag == '0) begin
            rx_d = '0; ry_d = '0; rcxx_d = '0; rcxy_d = '0; rcyy_d = '0;
            rs_d = 1'b1;
            st_d = ST_OUT;
          end
        end
        C_QXX: rcxx_d = u32sat(sm_mk(iyy_q[63] ^ det_q.neg, quo));
        C_QXY: rcxy_d = sat32(sm_mk(!ixy_q[63] ^ det_q.neg, quo));
        C_QYY: rcyy_d = u32sat(sm_mk(ixx_q[63] ^ det_q.neg, quo));
        C_X0:  t_d = sm_mk(vx_q[63], prod);
        C_X1:  t_d = sm_add(t_q, sm_mk(rcxy_q[31] ^ vy_q[63], prod));
        C_XA:  rx_d = satcw(sm_shr(t_q, 7'd32));
        C_Y0:  t_d = sm_mk(rcxy_q[31] ^ vx_q[63], prod);
        C_Y1:  t_d = sm_add(t_q, sm_mk(vy_q[63], prod));
        C_YA: begin
          ry_d = satcw(sm_shr(t_q, 7'd32));
          rs_d = sseen_q;
          st_d = ST_OUT;
        end
        S_QXX: rcxx_d = u32sat(sm_mk(1'b0, quo));
        S_QXY: rcxy_d = sat32(sm_mk(xy_q[31], quo));
        S_QYY: begin
          rcyy_d = u32sat(sm_mk(1'b0, quo));
          rx_d = mx_q;
          ry_d = my_q;
          rs_d = sseen_q;
          st_d = ST_OUT;
        end
        default: st_d = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      step_q  <= H_DETA;
      minw_q  <= MinWeightRst;
      pend_q  <= 1'b0;
      sseen_q <= 1'b0;
      ov_q    <= 1'b0;
      ixx_q   <= '0;
      ixy_q   <= '0;
      iyy_q   <= '0;
      vx_q    <= '0;
      vy_q    <= '0;
    end else begin
      st_q    <= st_d;
      step_q  <= step_d;
      pend_q  <= pend_d;
      sseen_q <= sseen_d;
      ov_q    <= ov_d;
      ixx_q   <= ixx_d;
      ixy_q   <= ixy_d;
      iyy_q   <= iyy_d;
      vx_q    <= vx_d;
      vy_q    <= vy_d;
      if (cfg_valid_i) minw_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q <= mx_d;   my_q <= my_d;   xx_q <= xx_d;  xy_q <= xy_d;  yy_q <= yy_d;
    w_q <= w_d;     last_q <= last_d;
    hxx_q <= hxx_d; hxy_q <= hxy_d; hyy_q <= hyy_d;
    p_q <= p_d;     det_q <= det_d;  t_q <= t_d;    nb_q <= nb_d;
    rx_q <= rx_d;   ry_q <= ry_d;
    rcxx_q <= rcxx_d; rcxy_q <= rcxy_d; rcyy_q <= rcyy_d;
    rs_q <= rs_d;
    if (load_out) begin
      ox_q   <= rx_q;
      oy_q   <= ry_q;
      ocxx_q <= rcxx_q;
      ocxy_q <= rcxy_q;
      ocyy_q <= rcyy_q;
      os_q   <= rs_q;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = OUT_W'({ocyy_q, ocxy_q, ocxx_q, oy_q, ox_q});
  assign m_axis_tuser  = os_q;

  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_start && div_start)) else $error("both units started");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_IDLE) |-> !mul_done && !div_done) else $error("unit done while idle");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready) else $error("ready after accept");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> m_axis_tvalid) else $error("result lost");

endmodule
